// ----- src/mpm_pkg.sv -----
// Shared types, register map and depth helpers for the masked pixel merge.
// No dependencies; used by every module in src.
`default_nettype none

package mpm_pkg;

	localparam int unsigned PIX_W  = 16;
	localparam int unsigned DIFF_W = PIX_W + 1;
	localparam int unsigned PROD_W = 2 * DIFF_W;
	localparam int unsigned SUM_W  = PROD_W + 1;
	// zero extension of a sample up to the sum width
	localparam int unsigned EXT_W  = SUM_W - PIX_W;
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;

	// register map
	localparam logic [ADDR_W-1:0] ADDR_DEPTH = 3'd0;
	localparam logic [ADDR_W-1:0] ADDR_MODE  = 3'd4;

	// depth codes
	localparam logic [1:0] DEPTH_10 = 2'd0;
	localparam logic [1:0] DEPTH_12 = 2'd1;
	localparam logic [1:0] DEPTH_14 = 2'd2;
	localparam logic [1:0] DEPTH_16 = 2'd3;

	// mask subsampling modes; the spare code behaves as 4:4:4
	localparam logic [1:0] MODE_444 = 2'd0;
	localparam logic [1:0] MODE_422 = 2'd1;
	localparam logic [1:0] MODE_420 = 2'd2;

	localparam logic [1:0] DEPTH_RESET = DEPTH_16;
	localparam logic [1:0] MODE_RESET  = MODE_444;

	typedef struct packed {
		logic [1:0] depth_code;
		logic [1:0] mask_mode;
	} cfg_t;

	function automatic logic [PIX_W-1:0] depth_max(input logic [1:0] code);
		logic [PIX_W-1:0] r;
		unique case (code)
			DEPTH_10: r = 16'h03FF;
			DEPTH_12: r = 16'h0FFF;
			DEPTH_14: r = 16'h3FFF;
			default:  r = 16'hFFFF;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] depth_shift(input logic [1:0] code);
		logic [3:0] r;
		unique case (code)
			DEPTH_10: r = 4'd10;
			DEPTH_12: r = 4'd12;
			DEPTH_14: r = 4'd14;
			default:  r = 4'd15;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- src/mpm_regs.sv -----
// APB-style configuration registers: sample depth and mask subsampling mode.
// Depends on mpm_pkg.
`default_nettype none

module mpm_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [mpm_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [mpm_pkg::DATA_W-1:0]   pwdata,
	output logic      [mpm_pkg::DATA_W-1:0]   prdata,
	output logic                              pready,
	output mpm_pkg::cfg_t                     cfg
);

	logic [1:0] depth_q;
	logic [1:0] mode_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= mpm_pkg::DEPTH_RESET;
			mode_q  <= mpm_pkg::MODE_RESET;
		end else if (wr_en) begin
			if (paddr == mpm_pkg::ADDR_DEPTH) begin
				depth_q <= pwdata[1:0];
			end
			if (paddr == mpm_pkg::ADDR_MODE) begin
				mode_q <= pwdata[1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == mpm_pkg::ADDR_DEPTH) begin
			prdata = {{(mpm_pkg::DATA_W-2){1'b0}}, depth_q};
		end else if (paddr == mpm_pkg::ADDR_MODE) begin
			prdata = {{(mpm_pkg::DATA_W-2){1'b0}}, mode_q};
		end
	end

	assign cfg.depth_code = depth_q;
	assign cfg.mask_mode  = mode_q;

endmodule

`default_nettype wire

// ----- src/mpm_mask_sel.sv -----
// Mask selection: single sample, rounded pair average or rounded quad average.
// Depends on mpm_pkg.
`default_nettype none

module mpm_mask_sel (
	input  wire logic [1:0]                mask_mode,
	input  wire logic [mpm_pkg::PIX_W-1:0] tl,
	input  wire logic [mpm_pkg::PIX_W-1:0] tr,
	input  wire logic [mpm_pkg::PIX_W-1:0] bl,
	input  wire logic [mpm_pkg::PIX_W-1:0] br,
	output logic      [mpm_pkg::PIX_W-1:0] mask
);

	logic [mpm_pkg::PIX_W:0]   pair_sum;
	logic [mpm_pkg::PIX_W:0]   left_sum;
	logic [mpm_pkg::PIX_W:0]   right_sum;
	logic [mpm_pkg::PIX_W:0]   quad_sum;
	logic [mpm_pkg::PIX_W-1:0] left_avg;
	logic [mpm_pkg::PIX_W-1:0] right_avg;

	always_comb begin
		pair_sum  = {1'b0, tl} + {1'b0, tr} + 17'd1;
		// vertical averages first, then across
		left_sum  = {1'b0, tl} + {1'b0, bl} + 17'd1;
		right_sum = {1'b0, tr} + {1'b0, br} + 17'd1;
		left_avg  = left_sum[mpm_pkg::PIX_W:1];
		right_avg = right_sum[mpm_pkg::PIX_W:1];
		quad_sum  = {1'b0, left_avg} + {1'b0, right_avg} + 17'd1;
		unique case (mask_mode)
			mpm_pkg::MODE_422: mask = pair_sum[mpm_pkg::PIX_W:1];
			mpm_pkg::MODE_420: mask = quad_sum[mpm_pkg::PIX_W:1];
			default:           mask = tl;
		endcase
	end

endmodule

`default_nettype wire

// ----- src/masked_pixel_merge_16bit.sv -----
// Top level of the masked pixel merge: registers, mask selection, blend pipeline.
// Depends on mpm_pkg, mpm_regs and mpm_mask_sel.
//
// One pixel may be started on every clock; busy stays low. Each accepted pixel
// gives one merged_pixel, marked by done, in start order, after it has passed
// the three register stages: mask averaging and source-minus-destination
// difference; the 17x17 signed multiply; the depth shift, add, special-case
// select and clamp. Results cannot be held off, so nothing in the pipeline ever
// stalls. Change the registers only while no pixel is in flight.
`default_nettype none

module masked_pixel_merge_16bit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [mpm_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [mpm_pkg::DATA_W-1:0]   pwdata,
	output logic      [mpm_pkg::DATA_W-1:0]   prdata,
	output logic                              pready,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [mpm_pkg::PIX_W-1:0]    dst_pixel,
	input  wire logic [mpm_pkg::PIX_W-1:0]    src_pixel,
	input  wire logic [mpm_pkg::PIX_W-1:0]    mask_top_left,
	input  wire logic [mpm_pkg::PIX_W-1:0]    mask_top_right,
	input  wire logic [mpm_pkg::PIX_W-1:0]    mask_bottom_left,
	input  wire logic [mpm_pkg::PIX_W-1:0]    mask_bottom_right,
	output logic                              done,
	output logic      [mpm_pkg::PIX_W-1:0]    merged_pixel
);

	mpm_pkg::cfg_t cfg;

	mpm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign busy = 1'b0;

	// stage 1: mask and difference
	logic [mpm_pkg::PIX_W-1:0]         mask_c;
	logic                              accept;
	logic                              valid_s1;
	logic [mpm_pkg::PIX_W-1:0]         dst_s1;
	logic [mpm_pkg::PIX_W-1:0]         src_s1;
	logic [mpm_pkg::PIX_W-1:0]         mask_s1;
	logic signed [mpm_pkg::DIFF_W-1:0] diff_s1;

	assign accept = start && !busy;

	mpm_mask_sel u_mask_sel (
		.mask_mode (cfg.mask_mode),
		.tl        (mask_top_left),
		.tr        (mask_top_right),
		.bl        (mask_bottom_left),
		.br        (mask_bottom_right),
		.mask      (mask_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dst_s1  <= dst_pixel;
			src_s1  <= src_pixel;
			mask_s1 <= mask_c;
			diff_s1 <= $signed({1'b0, src_pixel}) - $signed({1'b0, dst_pixel});
		end
	end

	// stage 2: multiply
	logic [mpm_pkg::PIX_W-1:0]         weight_c;
	logic signed [mpm_pkg::PROD_W-1:0] prod_c;
	logic                              valid_s2;
	logic [mpm_pkg::PIX_W-1:0]         dst_s2;
	logic [mpm_pkg::PIX_W-1:0]         src_s2;
	logic                              zero_s2;
	logic                              full_s2;
	logic signed [mpm_pkg::PROD_W-1:0] prod_s2;

	always_comb begin
		// 16-bit depth halves the mask so the weight stays within 15 bits
		weight_c = (cfg.depth_code == mpm_pkg::DEPTH_16) ? (mask_s1 >> 1) : mask_s1;
		prod_c   = diff_s1 * $signed({1'b0, weight_c});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			dst_s2  <= dst_s1;
			src_s2  <= src_s1;
			zero_s2 <= (mask_s1 == '0);
			full_s2 <= (mask_s1 == mpm_pkg::depth_max(cfg.depth_code));
			prod_s2 <= prod_c;
		end
	end

	// stage 3: shift, add, select, clamp
	logic [mpm_pkg::PIX_W-1:0]         max_c;
	logic signed [mpm_pkg::PROD_W-1:0] shifted_c;
	logic signed [mpm_pkg::SUM_W-1:0]  sum_c;
	logic signed [mpm_pkg::SUM_W-1:0]  pick_c;
	logic [mpm_pkg::PIX_W-1:0]         res_c;
	logic                              valid_s3;
	logic [mpm_pkg::PIX_W-1:0]         res_s3;

	always_comb begin
		max_c     = mpm_pkg::depth_max(cfg.depth_code);
		shifted_c = prod_s2 >>> mpm_pkg::depth_shift(cfg.depth_code);
		sum_c     = $signed({{mpm_pkg::EXT_W{1'b0}}, dst_s2})
			+ {shifted_c[mpm_pkg::PROD_W-1], shifted_c};
		priority if (zero_s2) begin
			pick_c = $signed({{mpm_pkg::EXT_W{1'b0}}, dst_s2});
		end else if (full_s2) begin
			pick_c = $signed({{mpm_pkg::EXT_W{1'b0}}, src_s2});
		end else begin
			pick_c = sum_c;
		end
		priority if (pick_c < 0) begin
			res_c = '0;
		end else if (pick_c > $signed({{mpm_pkg::EXT_W{1'b0}}, max_c})) begin
			res_c = max_c;
		end else begin
			res_c = pick_c[mpm_pkg::PIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			res_s3 <= res_c;
		end
	end

	assign done         = valid_s3;
	assign merged_pixel = res_s3;

	// every transfer yields a result, and no result appears otherwise
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##3 done)
		else $error("accepted pixel produced no result");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 3))
		else $error("result without a matching transfer");

	// results never exceed the configured depth maximum
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (merged_pixel <= mpm_pkg::depth_max(cfg.depth_code)))
		else $error("merged pixel above depth maximum");

endmodule

`default_nettype wire

// ----- sim/masked_pixel_merge_16bit_tb.sv -----
// Self-checking bench for masked_pixel_merge_16bit: a directed table, then random pixels
// over several depth and mask-mode settings, checked against table values or a blend predictor.
// Depends on mpm_pkg and the masked_pixel_merge_16bit RTL.
`timescale 1ns / 100ps

module masked_pixel_merge_16bit_tb;

	localparam logic [1:0] MODE_SPARE = 2'd3;

	typedef logic [mpm_pkg::PIX_W-1:0] sample_t;

	typedef struct packed {
		logic [mpm_pkg::PIX_W-1:0] dst;
		logic [mpm_pkg::PIX_W-1:0] src;
		logic [mpm_pkg::PIX_W-1:0] tl;
		logic [mpm_pkg::PIX_W-1:0] tr;
		logic [mpm_pkg::PIX_W-1:0] bl;
		logic [mpm_pkg::PIX_W-1:0] br;
	} pixel_t;

	typedef struct packed {
		logic [1:0]                depth;
		logic [1:0]                mode;
		pixel_t                    pix;
		logic                      typed;
		logic [mpm_pkg::PIX_W-1:0] want;
	} stim_row_t;

	localparam stim_row_t DIRECTED [0:22] = '{
		// reset setting: 16 bits, 4:4:4
		'{mpm_pkg::DEPTH_16, mpm_pkg::MODE_444,
			'{16'h1234, 16'hABCD, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, 16'h1234},
		'{mpm_pkg::DEPTH_16, mpm_pkg::MODE_444,
			'{16'h1234, 16'hABCD, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000}, 1'b1, 16'hABCD},
		'{mpm_pkg::DEPTH_16, mpm_pkg::MODE_444,
			'{16'h0000, 16'hFFFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, 16'h0000},
		'{mpm_pkg::DEPTH_16, mpm_pkg::MODE_444,
			'{16'hFFFF, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000}, 1'b0, 16'h0000},
		'{mpm_pkg::DEPTH_16, mpm_pkg::MODE_444,
			'{16'hFFFF, 16'h0000, 16'hFFFE, 16'h0000, 16'h0000, 16'h0000}, 1'b0, 16'h0000},
		// 10 bits: special masks, samples and mask above the maximum
		'{mpm_pkg::DEPTH_10, mpm_pkg::MODE_444,
			'{16'h0000, 16'h03FF, 16'h03FF, 16'h0000, 16'h0000, 16'h0000}, 1'b1, 16'h03FF},
		'{mpm_pkg::DEPTH_10, mpm_pkg::MODE_444,
			'{16'h03FF, 16'h0000, 16'h0000, 16'h03FF, 16'h03FF, 16'h03FF}, 1'b1, 16'h03FF},
		'{mpm_pkg::DEPTH_10, mpm_pkg::MODE_444,
			'{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, 16'h03FF},
		'{mpm_pkg::DEPTH_10, mpm_pkg::MODE_444,
			'{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000}, 1'b1, 16'h03FF},
		'{mpm_pkg::DEPTH_10, mpm_pkg::MODE_444,
			'{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000}, 1'b1, 16'h0000},
		'{mpm_pkg::DEPTH_10, mpm_pkg::MODE_444,
			'{16'h0200, 16'h0100, 16'h0155, 16'h0000, 16'h0000, 16'h0000}, 1'b0, 16'h0000},
		// 12 bits, pair average; lower row must be ignored
		'{mpm_pkg::DEPTH_12, mpm_pkg::MODE_422,
			'{16'h0010, 16'h0ABC, 16'h0FFF, 16'h0FFF, 16'h0000, 16'h0000}, 1'b1, 16'h0ABC},
		'{mpm_pkg::DEPTH_12, mpm_pkg::MODE_422,
			'{16'h0000, 16'h0FFF, 16'h0001, 16'h0000, 16'h0000, 16'h0000}, 1'b0, 16'h0000},
		'{mpm_pkg::DEPTH_12, mpm_pkg::MODE_422,
			'{16'h0123, 16'h0FFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF}, 1'b1, 16'h0123},
		'{mpm_pkg::DEPTH_12, mpm_pkg::MODE_422,
			'{16'h0800, 16'h0100, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000}, 1'b0, 16'h0000},
		// 14 bits, quad average
		'{mpm_pkg::DEPTH_14, mpm_pkg::MODE_420,
			'{16'h1111, 16'h2222, 16'h3FFF, 16'h3FFF, 16'h3FFF, 16'h3FFF}, 1'b1, 16'h2222},
		'{mpm_pkg::DEPTH_14, mpm_pkg::MODE_420,
			'{16'h1111, 16'h2222, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, 16'h1111},
		'{mpm_pkg::DEPTH_14, mpm_pkg::MODE_420,
			'{16'h0000, 16'h3FFF, 16'h0001, 16'h0000, 16'h0000, 16'h0000}, 1'b0, 16'h0000},
		'{mpm_pkg::DEPTH_14, mpm_pkg::MODE_420,
			'{16'h3FFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, 16'h0000},
		// spare mode acts as 4:4:4, then one 12-bit 4:4:4 row
		'{mpm_pkg::DEPTH_16, MODE_SPARE,
			'{16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, 16'h5555},
		'{mpm_pkg::DEPTH_16, MODE_SPARE,
			'{16'h5555, 16'hAAAA, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000}, 1'b1, 16'hAAAA},
		'{mpm_pkg::DEPTH_16, MODE_SPARE,
			'{16'h1000, 16'hF000, 16'h4321, 16'hFFFF, 16'h0000, 16'hFFFF}, 1'b0, 16'h0000},
		'{mpm_pkg::DEPTH_12, mpm_pkg::MODE_444,
			'{16'h0800, 16'h07FF, 16'h0800, 16'h0000, 16'h0000, 16'h0000}, 1'b0, 16'h0000}
	};

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [mpm_pkg::ADDR_W-1:0]   paddr = '0;
	logic [mpm_pkg::DATA_W-1:0]   pwdata = '0;
	logic [mpm_pkg::DATA_W-1:0]   prdata;
	logic                         pready;
	logic                         start = 1'b0;
	logic                         busy;
	logic [mpm_pkg::PIX_W-1:0]    dst_pixel = '0;
	logic [mpm_pkg::PIX_W-1:0]    src_pixel = '0;
	logic [mpm_pkg::PIX_W-1:0]    mask_top_left = '0;
	logic [mpm_pkg::PIX_W-1:0]    mask_top_right = '0;
	logic [mpm_pkg::PIX_W-1:0]    mask_bottom_left = '0;
	logic [mpm_pkg::PIX_W-1:0]    mask_bottom_right = '0;
	logic                         done;
	logic [mpm_pkg::PIX_W-1:0]    merged_pixel;

	mpm_pkg::cfg_t                cur_cfg = '{depth_code: mpm_pkg::DEPTH_RESET,
		mask_mode: mpm_pkg::MODE_RESET};
	logic [mpm_pkg::PIX_W-1:0]    pending_merged [$];
	logic [mpm_pkg::PIX_W-1:0]    merged_want;
	int unsigned                  mismatches = 0;
	bit                           steady = 1'b0;

	masked_pixel_merge_16bit uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.start            (start),
		.busy             (busy),
		.dst_pixel        (dst_pixel),
		.src_pixel        (src_pixel),
		.mask_top_left    (mask_top_left),
		.mask_top_right   (mask_top_right),
		.mask_bottom_left (mask_bottom_left),
		.mask_bottom_right(mask_bottom_right),
		.done             (done),
		.merged_pixel     (merged_pixel)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [mpm_pkg::PIX_W-1:0] depth_top(input logic [1:0] depth);
		return sample_t'((32'd1 << (10 + 2 * depth)) - 1);
	endfunction

	// Blend one pixel under the given setting; the shift floors toward minus infinity.
	function automatic logic [mpm_pkg::PIX_W-1:0] blend_sample(input mpm_pkg::cfg_t c,
		input pixel_t p);
		int unsigned bits, mask, lft, rgt, sh;
		longint      maxv, res, m;
		bits = 10 + 2 * c.depth_code;
		maxv = (longint'(1) << bits) - 1;
		case (c.mask_mode)
			mpm_pkg::MODE_422: mask = (p.tl + p.tr + 1) >> 1;
			mpm_pkg::MODE_420: begin
				lft  = (p.tl + p.bl + 1) >> 1;
				rgt  = (p.tr + p.br + 1) >> 1;
				mask = (lft + rgt + 1) >> 1;
			end
			default:  mask = p.tl;
		endcase
		if (mask == 0) begin
			res = p.dst;
		end else if (longint'(mask) == maxv) begin
			res = p.src;
		end else begin
			if (bits < 16) begin
				m  = mask;
				sh = bits;
			end else begin
				m  = mask >> 1;
				sh = 15;
			end
			res = longint'(p.dst) + (((longint'(p.src) - longint'(p.dst)) * m) >>> sh);
		end
		if (res < 0)
			res = 0;
		if (res > maxv)
			res = maxv;
		return res[mpm_pkg::PIX_W-1:0];
	endfunction

	// Bias towards the edges of the depth, with some full 16-bit values.
	function automatic logic [mpm_pkg::PIX_W-1:0] draw_sample(
		input logic [mpm_pkg::PIX_W-1:0] top);
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return top;
			2:       return top - 1'b1;
			3, 4:    return sample_t'($urandom);
			default: return sample_t'($urandom) & top;
		endcase
	endfunction

	function automatic pixel_t draw_pixel(input logic [1:0] depth);
		pixel_t                    p;
		logic [mpm_pkg::PIX_W-1:0] top, fill;
		top   = depth_top(depth);
		p.dst = draw_sample(top);
		p.src = draw_sample(top);
		if ($urandom_range(0, 4) == 0) begin
			// uniform mask so every average lands on zero or full scale
			fill = $urandom_range(0, 1) ? top : '0;
			p.tl = fill;
			p.tr = fill;
			p.bl = fill;
			p.br = fill;
		end else begin
			p.tl = draw_sample(top);
			p.tr = draw_sample(top);
			p.bl = draw_sample(top);
			p.br = draw_sample(top);
		end
		return p;
	endfunction

	task automatic send_pixel(input pixel_t p, input logic typed,
		input logic [mpm_pkg::PIX_W-1:0] want);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 18);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start             <= 1'b1;
		dst_pixel         <= p.dst;
		src_pixel         <= p.src;
		mask_top_left     <= p.tl;
		mask_top_right    <= p.tr;
		mask_bottom_left  <= p.bl;
		mask_bottom_right <= p.br;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_merged.push_back(typed ? want : blend_sample(cur_cfg, p));
	endtask

	// Hold off until every outstanding pixel has come back.
	task automatic settle();
		start <= 1'b0;
		while (pending_merged.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [mpm_pkg::ADDR_W-1:0] addr, input logic [1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {{(mpm_pkg::DATA_W-2){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [1:0] depth, input logic [1:0] mode);
		settle();
		write_reg(mpm_pkg::ADDR_DEPTH, depth);
		cur_cfg.depth_code = depth;
		write_reg(mpm_pkg::ADDR_MODE, mode);
		cur_cfg.mask_mode = mode;
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (pending_merged.size() == 0) begin
				$error("merged_pixel: no result expected, got 0x%h", merged_pixel);
				mismatches++;
			end else begin
				merged_want = pending_merged.pop_front();
				if (merged_pixel !== merged_want) begin
					$error("merged_pixel: expected 0x%h, got 0x%h", merged_want, merged_pixel);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		logic [1:0] depth_plan [0:7];
		logic [1:0] mode_plan  [0:7];
		depth_plan = '{mpm_pkg::DEPTH_10, mpm_pkg::DEPTH_16, mpm_pkg::DEPTH_12,
			mpm_pkg::DEPTH_14, 2'd0, 2'd0, 2'd0, 2'd0};
		mode_plan  = '{mpm_pkg::MODE_444, mpm_pkg::MODE_420, mpm_pkg::MODE_422,
			MODE_SPARE, 2'd0, 2'd0, 2'd0, 2'd0};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(DIRECTED); i++) begin
			if (DIRECTED[i].depth != cur_cfg.depth_code || DIRECTED[i].mode != cur_cfg.mask_mode)
				set_config(DIRECTED[i].depth, DIRECTED[i].mode);
			send_pixel(DIRECTED[i].pix, DIRECTED[i].typed, DIRECTED[i].want);
		end

		// first four settings are fixed extremes, the rest are drawn
		for (int ph = 4; ph < 8; ph++) begin
			depth_plan[ph] = 2'($urandom_range(0, 3));
			mode_plan[ph]  = 2'($urandom_range(0, 3));
		end
		for (int ph = 0; ph < 8; ph++) begin
			set_config(depth_plan[ph], mode_plan[ph]);
			for (int n = 0; n < 75; n++) begin
				if (n % 20 == 0)
					steady = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 49) == 0)
					settle();
				send_pixel(draw_pixel(cur_cfg.depth_code), 1'b0, '0);
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_merged.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
